>>> rtl/core/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

  localparam int COUNT_W   = 7;
  localparam int TAB_DEPTH = 2 ** COUNT_W;
  localparam int IDX_W     = 26;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 3;

  // colour constants as single-precision significands
  localparam logic [23:0] GREEN_MANT  = 24'd15938355;
  localparam int          GREEN_SHIFT = 23;
  localparam logic [23:0] BLUE_MANT   = 24'd9856614;
  localparam int          BLUE_SHIFT  = 22;

  // register reset values
  localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd536870912;
  localparam logic signed [31:0] RST_IMAG_ORIGIN = -32'sd402653184;
  localparam logic signed [31:0] RST_REAL_STEP   = 32'sd786432;
  localparam logic signed [31:0] RST_IMAG_STEP   = 32'sd786432;
  localparam logic [DIM_W-1:0]   RST_WIDTH       = 13'd1024;
  localparam logic [DIM_W-1:0]   RST_HEIGHT      = 13'd1024;
  localparam logic [2:0]         RST_STRIDE      = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_ORIGIN    = 3'd0,
    REG_IMAG_ORIGIN    = 3'd1,
    REG_REAL_STEP      = 3'd2,
    REG_IMAG_STEP      = 3'd3,
    REG_IMAGE_WIDTH    = 3'd4,
    REG_IMAGE_HEIGHT   = 3'd5,
    REG_CHANNEL_STRIDE = 3'd6
  } mbe_reg_t;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } mbe_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   byte_index;
    logic [COUNT_W-1:0] escape_count;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               out_of_frame;
  } mbe_out_t;

  typedef struct packed {
    logic signed [31:0] real_origin;
    logic signed [31:0] imag_origin;
    logic signed [31:0] real_step;
    logic signed [31:0] imag_step;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [2:0]         channel_stride;
  } mbe_cfg_t;

  typedef struct packed {
    logic signed [31:0] a0;
    logic signed [31:0] b0;
    logic signed [31:0] a1;
    logic signed [31:0] b1;
    logic signed [31:0] a2;
    logic signed [31:0] b2;
  } mbe_mul_ops_t;

  typedef struct packed {
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
  } mbe_mul_prod_t;

  typedef struct packed {
    logic               load;
    logic               oof;
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   idx_sum;
  } mbe_res_req_t;

  // trunc(n * m * 2^-k) with n*m first rounded to 24 significant bits, ties even
  function automatic logic [7:0] mbe_float_scale(input logic [COUNT_W-1:0] n,
                                                 input logic [23:0] m,
                                                 input int k);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] r;
    int          len;
    int          d;
    p   = 64'(n) * 64'(m);
    len = 0;
    for (int i = 0; i < 64; i++) begin
      if (p[i]) len = i + 1;
    end
    if (len > 24) begin
      d    = len - 24;
      q    = p >> d;
      rem  = p & ((64'd1 << d) - 64'd1);
      half = 64'd1 << (d - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      p = q << d;
    end
    r = p >> k;
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mbe_mul_unit.sv
`default_nettype none

// Three signed 32x32 multipliers with registered products.
module mbe_mul_unit (
  input  wire logic                  clk,
  input  wire mbe_pkg::mbe_mul_ops_t ops,
  output mbe_pkg::mbe_mul_prod_t     prod
);
  import mbe_pkg::*;

  mbe_mul_prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r.p0 <= ops.a0 * ops.b0;
    prod_r.p1 <= ops.a1 * ops.b1;
    prod_r.p2 <= ops.a2 * ops.b2;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

>>> rtl/core/mbe_result.sv
`default_nettype none

// Output register: colour lookup, byte index scaling, result handshake.
module mbe_result (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mbe_pkg::mbe_res_req_t req,
  input  wire logic [2:0]            stride,
  output logic                       free,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output mbe_pkg::mbe_out_t          out_data
);
  import mbe_pkg::*;

  logic [7:0]       green_tab [TAB_DEPTH];
  logic [7:0]       blue_tab  [TAB_DEPTH];
  logic [IDX_W+2:0] idx_prod;
  mbe_out_t         data_nxt;
  mbe_out_t         out_data_r;
  logic             out_valid_r;

  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
    assign green_tab[g] = mbe_float_scale(COUNT_W'(g), GREEN_MANT, GREEN_SHIFT);
    assign blue_tab[g]  = mbe_float_scale(COUNT_W'(g), BLUE_MANT, BLUE_SHIFT);
  end

  assign idx_prod = (IDX_W+3)'(req.idx_sum) * (IDX_W+3)'(stride);

  always_comb begin
    data_nxt = '0;
    if (req.oof) begin
      data_nxt.out_of_frame = 1'b1;
    end else begin
      data_nxt.byte_index   = idx_prod[IDX_W-1:0];
      data_nxt.escape_count = req.count;
      data_nxt.red          = 8'({req.count, 1'b0});
      data_nxt.green        = green_tab[req.count];
      data_nxt.blue         = blue_tab[req.count];
    end
  end

  assign free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      out_data_r <= data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/mbe_seq.sv
`default_nettype none

// Sequencer and z datapath: c setup, then one multiply/update pair per iteration.
module mbe_seq #(
  parameter int MAX_ITERATIONS = 100,
  parameter int MAX_DIMENSION  = 4096,
  parameter int FRACTION_BITS  = 28
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire mbe_pkg::mbe_in_t       in_data,
  input  wire mbe_pkg::mbe_cfg_t      cfg,
  output mbe_pkg::mbe_mul_ops_t       mul_ops,
  input  wire mbe_pkg::mbe_mul_prod_t mul_prod,
  input  wire logic                   res_free,
  output mbe_pkg::mbe_res_req_t       res_req
);
  import mbe_pkg::*;

  localparam int ZW = 66 - FRACTION_BITS;   // shifted product plus c, with carry
  localparam int CW = 46;                   // origin + 12b x 32b product, with carry
  localparam logic [63:0]        ESC_LIMIT = 64'd4 << (2 * FRACTION_BITS);
  localparam logic [DIM_W-1:0]   DIM_MAX   = DIM_W'(MAX_DIMENSION);
  localparam logic [COUNT_W-1:0] ITER_MAX  = COUNT_W'(MAX_ITERATIONS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_C,
    S_ADD_C,
    S_MUL_Z,
    S_UPD_Z,
    S_WRITE
  } state_t;

  state_t             state_r;
  logic [11:0]        col_r;
  logic [11:0]        row_r;
  logic               oof_r;
  logic signed [31:0] cre_r;
  logic signed [31:0] cim_r;
  logic signed [31:0] re_r;
  logic signed [31:0] im_r;
  logic [COUNT_W-1:0] iter_r;
  logic [COUNT_W-1:0] iter_nxt;
  logic [IDX_W-1:0]   idx_sum_r;

  logic [DIM_W-1:0]   w_lim;
  logic [DIM_W-1:0]   h_lim;
  logic               in_oof;
  logic signed [CW-1:0] c_re_sum;
  logic signed [CW-1:0] c_im_sum;
  logic signed [63:0] diff;
  logic signed [63:0] re_sh;
  logic signed [63:0] im_sh;
  logic signed [ZW-1:0] re_sum;
  logic signed [ZW-1:0] im_sum;
  logic [63:0]        mag;
  logic               escape;

  function automatic logic signed [31:0] sat_c(input logic signed [CW-1:0] v);
    if (&v[CW-1:31] || ~|v[CW-1:31]) return v[31:0];
    return v[CW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [31:0] sat_z(input logic signed [ZW-1:0] v);
    if (&v[ZW-1:31] || ~|v[ZW-1:31]) return v[31:0];
    return v[ZW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // frame bounds clamp to the largest supported dimension
  assign w_lim  = (cfg.image_width  > DIM_MAX) ? DIM_MAX : cfg.image_width;
  assign h_lim  = (cfg.image_height > DIM_MAX) ? DIM_MAX : cfg.image_height;
  assign in_oof = ({1'b0, in_data.column} >= w_lim) || ({1'b0, in_data.row} >= h_lim);

  assign c_re_sum = CW'(cfg.real_origin) + $signed(mul_prod.p0[CW-1:0]);
  assign c_im_sum = CW'(cfg.imag_origin) + $signed(mul_prod.p1[CW-1:0]);

  // p0 = re^2, p1 = im^2, p2 = re*im during the update step
  assign diff   = mul_prod.p0 - mul_prod.p1;
  assign re_sh  = diff >>> FRACTION_BITS;
  assign im_sh  = mul_prod.p2 >>> (FRACTION_BITS - 1);
  assign re_sum = $signed(re_sh[ZW-1:0]) + ZW'(cre_r);
  assign im_sum = $signed(im_sh[ZW-1:0]) + ZW'(cim_r);
  assign mag    = $unsigned(mul_prod.p0) + $unsigned(mul_prod.p1);
  assign escape = mag > ESC_LIMIT;

  assign iter_nxt = iter_r + COUNT_W'(1);

  always_comb begin
    if (state_r == S_MUL_C) begin
      mul_ops.a0 = $signed({20'd0, col_r});
      mul_ops.b0 = cfg.real_step;
      mul_ops.a1 = $signed({20'd0, row_r});
      mul_ops.b1 = cfg.imag_step;
      mul_ops.a2 = $signed({20'd0, row_r});
      mul_ops.b2 = $signed({19'd0, cfg.image_width});
    end else begin
      mul_ops.a0 = re_r;
      mul_ops.b0 = re_r;
      mul_ops.a1 = im_r;
      mul_ops.b1 = im_r;
      mul_ops.a2 = re_r;
      mul_ops.b2 = im_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            col_r   <= in_data.column;
            row_r   <= in_data.row;
            oof_r   <= in_oof;
            iter_r  <= '0;
            re_r    <= '0;
            im_r    <= '0;
            state_r <= in_oof ? S_WRITE : S_MUL_C;
          end
        end
        S_MUL_C: begin
          state_r <= S_ADD_C;
        end
        S_ADD_C: begin
          cre_r     <= sat_c(c_re_sum);
          cim_r     <= sat_c(c_im_sum);
          idx_sum_r <= IDX_W'(col_r) + mul_prod.p2[IDX_W-1:0];
          state_r   <= S_MUL_Z;
        end
        S_MUL_Z: begin
          state_r <= S_UPD_Z;
        end
        S_UPD_Z: begin
          if (escape) begin
            state_r <= S_WRITE;
          end else begin
            re_r    <= sat_z(re_sum);
            im_r    <= sat_z(im_sum);
            iter_r  <= iter_nxt;
            state_r <= (iter_nxt == ITER_MAX) ? S_WRITE : S_MUL_Z;
          end
        end
        S_WRITE: begin
          if (res_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = !rst_n || (state_r != S_IDLE);
  assign res_req.load    = (state_r == S_WRITE) && res_free;
  assign res_req.oof     = oof_r;
  assign res_req.count   = iter_r;
  assign res_req.idx_sum = idx_sum_r;

endmodule

`default_nettype wire

>>> rtl/core/mandelbrot_escape_pixel_unit.sv
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid / in_stall | mbe_in_t  : column, row
// out_     | output    | out_valid/out_stall | mbe_out_t : byte_index, count, colours, flag
// cfg_     | input     | cfg_valid/cfg_ready | cfg_index (3b), cfg_data (32b)
//
// One pixel at a time. An out-of-frame pixel skips c setup and the iteration loop;
// others run min(escape_count + 1, MAX_ITERATIONS) multiply/update iterations.
// In each iteration the shared multiplier set (re^2, im^2, re*im) registers its
// products, then one update/escape-check step feeds the next z.
// Reset (synchronous, rst_n low) returns registers to their defaults and empties
// the output register. A stalled result is held; a new transaction is accepted
// while it waits, but its result is loaded only once the old one has gone.
module mandelbrot_escape_pixel_unit #(
  parameter int MAX_ITERATIONS = 100,
  parameter int MAX_DIMENSION  = 4096,
  parameter int FRACTION_BITS  = 28
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pixel input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire mbe_pkg::mbe_in_t                in_data,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output mbe_pkg::mbe_out_t                    out_data,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import mbe_pkg::*;

  mbe_cfg_t      cfg_r;
  mbe_cfg_t      cfg_nxt;
  mbe_mul_ops_t  mul_ops;
  mbe_mul_prod_t mul_prod;
  mbe_res_req_t  res_req;
  logic          res_free;

  // Register file. Writes beyond the last index are dropped.
  assign cfg_ready = rst_n;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (mbe_reg_t'(cfg_index))
        REG_REAL_ORIGIN:    cfg_nxt.real_origin    = cfg_data;
        REG_IMAG_ORIGIN:    cfg_nxt.imag_origin    = cfg_data;
        REG_REAL_STEP:      cfg_nxt.real_step      = cfg_data;
        REG_IMAG_STEP:      cfg_nxt.imag_step      = cfg_data;
        REG_IMAGE_WIDTH:    cfg_nxt.image_width    = cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_nxt.image_height   = cfg_data[DIM_W-1:0];
        REG_CHANNEL_STRIDE: cfg_nxt.channel_stride = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.real_origin    <= RST_REAL_ORIGIN;
      cfg_r.imag_origin    <= RST_IMAG_ORIGIN;
      cfg_r.real_step      <= RST_REAL_STEP;
      cfg_r.imag_step      <= RST_IMAG_STEP;
      cfg_r.image_width    <= RST_WIDTH;
      cfg_r.image_height   <= RST_HEIGHT;
      cfg_r.channel_stride <= RST_STRIDE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer: frame check, c setup, iteration loop, hand-off to output reg
  mbe_seq #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .MAX_DIMENSION  (MAX_DIMENSION),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .mul_ops  (mul_ops),
    .mul_prod (mul_prod),
    .res_free (res_free),
    .res_req  (res_req)
  );

  // Shared multiplier set: coordinate*step and row*width during setup,
  // re^2 / im^2 / re*im during each iteration.
  mbe_mul_unit u_mul (
    .clk  (clk),
    .ops  (mul_ops),
    .prod (mul_prod)
  );

  // Output register with colour tables and stride scaling
  mbe_result u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (res_req),
    .stride    (cfg_r.channel_stride),
    .free      (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/mbe_checker.sv
`default_nettype none

module mbe_checker #(
  parameter int MAX_ITERATIONS = 100
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire mbe_pkg::mbe_out_t out_data
);
  import mbe_pkg::*;

  localparam logic [COUNT_W-1:0] ITER_MAX = COUNT_W'(MAX_ITERATIONS);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one pixel at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a pixel is in flight");

  a_oof_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_frame |->
      out_data.byte_index == '0 && out_data.escape_count == '0 &&
      out_data.red == '0 && out_data.green == '0 && out_data.blue == '0)
    else $error("out-of-frame result carries data");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.escape_count <= ITER_MAX &&
                  out_data.red == 8'({out_data.escape_count, 1'b0}))
    else $error("escape count or red byte inconsistent");

endmodule

bind mandelbrot_escape_pixel_unit mbe_checker #(
  .MAX_ITERATIONS (MAX_ITERATIONS)
) u_mbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mbe_pkg::*;

  // Block parameters, kept at the defaults of the unit
  localparam int ITER_CAP = 100;
  localparam int MAX_DIM  = 4096;
  localparam int FRAC     = 28;

  // |z|^2 escape bound, 4.0 at twice the fraction width
  localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FRAC);

  // 1.9f and 2.35f as 24-bit significands with their binary exponents
  localparam longint unsigned GREEN_SIG = 64'd15938355;
  localparam int              GREEN_EXP = 23;
  localparam longint unsigned BLUE_SIG  = 64'd9856614;
  localparam int              BLUE_EXP  = 22;

  // 3.0 in Q4.28, the span a view is built around
  localparam longint FULL_SPAN = 64'sd805306368;

  // Index past the end of the register map; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int HOLD_PHASE      = 3;
  localparam int LONG_HOLD       = 1000;
  localparam int TAIL_CYCLES     = 250;      // beyond the worst case for one pixel
  localparam int CYCLE_LIMIT     = 1500000;
  localparam int REPORT_LIMIT    = 10;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  mbe_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mbe_out_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  // Local copy of the register file, as the block should hold it
  mbe_cfg_t frame_cfg;

  mbe_in_t  pixel_q[$];      // pixels waiting to be offered
  mbe_out_t rendered_q[$];   // rendered pixels still owed by the block

  int   items_queued = 0;
  int   results_seen = 0;
  int   fail_count   = 0;
  int   report_count = 0;
  int   idle_level   = 0;    // 0: back to back, 1: light gaps, 2: heavy with long gaps
  logic pixel_taken  = 1'b0;
  logic hold_request = 1'b0;
  logic hold_started = 1'b0;
  int   hold_left    = 0;
  int   stall_left   = 0;
  int   send_gap     = 0;
  mbe_out_t want, got;

  mandelbrot_escape_pixel_unit #(
    .MAX_ITERATIONS(ITER_CAP),
    .MAX_DIMENSION (MAX_DIM),
    .FRACTION_BITS (FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pixel predictor
  // ---------------------------------------------------------------------------

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Iterations of z <- z^2 + c before |z|^2 passes 4; squares are exact, the
  // shifts floor, and each new component is clamped to 32 bits.
  function automatic int unsigned orbit_length(longint c_re, longint c_im);
    longint      zr, zi, sq_r, sq_i, xprod;
    logic [63:0] mag;
    zr = 0;
    zi = 0;
    for (int n = 0; n < ITER_CAP; n++) begin
      sq_r = zr * zr;
      sq_i = zi * zi;
      mag  = $unsigned(sq_r) + $unsigned(sq_i);
      if (mag > ESC_BOUND) return n;
      xprod = zr * zi;
      zr = sat_q(((sq_r - sq_i) >>> FRAC) + c_re);
      zi = sat_q((xprod >>> (FRAC - 1)) + c_im);
    end
    return ITER_CAP;
  endfunction

  // count * constant as single precision gives it (24-bit significand, ties to
  // even), then truncated toward zero
  function automatic logic [7:0] colour_byte(int unsigned n, longint unsigned sig,
                                             int scale);
    longint unsigned prod, keep, spill, half;
    int              drop;
    prod = n * sig;
    drop = 0;
    while ((prod >> drop) >= 64'd16777216) drop++;
    if (drop > 0) begin
      keep  = prod >> drop;
      spill = prod & ((64'd1 << drop) - 64'd1);
      half  = 64'd1 << (drop - 1);
      if (spill > half || (spill == half && keep[0])) keep++;
      prod = keep << drop;
    end
    return 8'(prod >> scale);
  endfunction

  function automatic mbe_out_t render_pixel(mbe_in_t px);
    mbe_out_t    r;
    longint      c_re, c_im;
    logic [63:0] flat;
    int unsigned n, wb, hb;
    r  = '0;
    // frame bounds are clamped, the row pitch below is not
    wb = (frame_cfg.image_width > MAX_DIM) ? MAX_DIM : frame_cfg.image_width;
    hb = (frame_cfg.image_height > MAX_DIM) ? MAX_DIM : frame_cfg.image_height;
    if (px.column >= wb || px.row >= hb) begin
      r.out_of_frame = 1'b1;
      return r;
    end
    c_re = sat_q(longint'($signed(frame_cfg.real_origin))
                 + longint'(px.column) * longint'($signed(frame_cfg.real_step)));
    c_im = sat_q(longint'($signed(frame_cfg.imag_origin))
                 + longint'(px.row) * longint'($signed(frame_cfg.imag_step)));
    n    = orbit_length(c_re, c_im);
    flat = (64'(px.column) + 64'(px.row) * 64'(frame_cfg.image_width))
           * 64'(frame_cfg.channel_stride);
    r.byte_index   = flat[IDX_W-1:0];
    r.escape_count = 7'(n);
    r.red          = 8'(2 * n);
    r.green        = colour_byte(n, GREEN_SIG, GREEN_EXP);
    r.blue         = colour_byte(n, BLUE_SIG, BLUE_EXP);
    return r;
  endfunction

  function automatic string describe(mbe_out_t r);
    return $sformatf("idx=%0d count=%0d rgb=%0d/%0d/%0d oof=%0b",
                     r.byte_index, r.escape_count, r.red, r.green, r.blue,
                     r.out_of_frame);
  endfunction

  // Length of an idle stretch; most are short, level 2 adds a few long ones
  function automatic int idle_run(int level);
    int r;
    r = $urandom_range(0, 99);
    if (level == 0) return 0;
    if (level == 1) return (r < 8) ? $urandom_range(1, 3) : 0;
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: changes on the falling edge, moves on once the current
  // transaction has been taken at the rising edge before.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pixel_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_data  <= pixel_q.pop_front();
        in_valid <= 1'b1;
        send_gap = idle_run(idle_level);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver stall. The long hold-off is counted here, on its own, so
  // the sender keeps offering pixels while the block backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_run(idle_level);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted pixel, checks every accepted result
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) rendered_q.push_back(render_pixel(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        got = out_data;
        if (rendered_q.size() == 0) begin
          fail_count++;
          report_count++;
          if (report_count <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: %s", $time, describe(got));
        end else begin
          want = rendered_q.pop_front();
          if (got.byte_index !== want.byte_index || got.escape_count !== want.escape_count
              || got.red !== want.red || got.green !== want.green
              || got.blue !== want.blue || got.out_of_frame !== want.out_of_frame) begin
            fail_count++;
            report_count++;
            if (report_count <= REPORT_LIMIT)
              $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                       describe(want), describe(got));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_pixel(int col, int row);
    mbe_in_t px;
    px.column = 12'(col);
    px.row    = 12'(row);
    pixel_q.push_back(px);
    items_queued++;
  endfunction

  // Pixels are queued just after a rising edge, clear of the driver's edge
  task automatic begin_batch(int level);
    @(posedge clk);
    idle_level = level;
  endtask

  // Sender pause: every queued pixel has come back as a result
  task automatic wait_drained();
    do @(negedge clk); while (results_seen < items_queued);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_REAL_ORIGIN:    frame_cfg.real_origin    = value;
      REG_IMAG_ORIGIN:    frame_cfg.imag_origin    = value;
      REG_REAL_STEP:      frame_cfg.real_step      = value;
      REG_IMAG_STEP:      frame_cfg.imag_step      = value;
      REG_IMAGE_WIDTH:    frame_cfg.image_width    = value[DIM_W-1:0];
      REG_IMAGE_HEIGHT:   frame_cfg.image_height   = value[DIM_W-1:0];
      REG_CHANNEL_STRIDE: frame_cfg.channel_stride = value[2:0];
      default: ;          // outside the map: dropped
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small frames, now and then the largest and oversized ones
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 48);
    if (r < 17) return $urandom_range(49, MAX_DIM);
    if (r < 19) return MAX_DIM;
    return $urandom_range(MAX_DIM + 1, 8191);
  endfunction

  // New random view. Usually the frame covers the set or zooms near its edge,
  // so the counts spread; once in a while everything is random.
  task automatic choose_view();
    int          w, h, we, he, zoom;
    logic [31:0] ro, io, rs, ims, stride;
    w    = pick_dim();
    h    = pick_dim();
    we   = (w > MAX_DIM) ? MAX_DIM : w;
    he   = (h > MAX_DIM) ? MAX_DIM : h;
    zoom = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if ($urandom_range(0, 15) == 0) begin
      ro  = $urandom();
      io  = $urandom();
      rs  = $urandom();
      ims = $urandom();
    end else if (zoom != 0) begin
      ro  = -214748365 + $urandom_range(0, 53687091);
      io  = $urandom_range(0, 53687091);
      rs  = 32'((FULL_SPAN / we) >>> zoom) + 32'd1;
      ims = 32'((FULL_SPAN / he) >>> zoom) + 32'd1;
    end else begin
      ro  = -671088640 + $urandom_range(0, 268435456);
      io  = -402653184 + $urandom_range(0, 134217728);
      rs  = 32'(FULL_SPAN / we);
      ims = 32'(FULL_SPAN / he);
    end
    stride = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 4) : $urandom_range(0, 7);
    write_reg(REG_REAL_ORIGIN, ro);
    write_reg(REG_IMAG_ORIGIN, io);
    write_reg(REG_REAL_STEP, rs);
    write_reg(REG_IMAG_STEP, ims);
    // junk in the unused upper bits must be dropped
    write_reg(REG_IMAGE_WIDTH, ($urandom() & ~32'h1FFF) | 32'(w));
    write_reg(REG_IMAGE_HEIGHT, ($urandom() & ~32'h1FFF) | 32'(h));
    write_reg(REG_CHANNEL_STRIDE, ($urandom() & ~32'h7) | stride);
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("watchdog expired after %0d cycles", cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int wb, hb, col, row;

    frame_cfg.real_origin    = RST_REAL_ORIGIN;
    frame_cfg.imag_origin    = RST_IMAG_ORIGIN;
    frame_cfg.real_step      = RST_REAL_STEP;
    frame_cfg.imag_step      = RST_IMAG_STEP;
    frame_cfg.image_width    = RST_WIDTH;
    frame_cfg.image_height   = RST_HEIGHT;
    frame_cfg.channel_stride = RST_STRIDE;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset view, -2-1.5i at the top left, 3/1024 per pixel
    begin_batch(1);
    queue_pixel(0, 0);           // escapes at once
    queue_pixel(512, 512);       // -0.5+0i, never escapes
    queue_pixel(400, 512);       // period-two bulb
    queue_pixel(300, 600);
    queue_pixel(1023, 1023);     // last pixel in frame
    queue_pixel(1024, 0);        // one column past the edge
    queue_pixel(0, 1024);        // one row past the edge
    queue_pixel(4095, 4095);
    wait_drained();

    // c saturates both ways: origin and step at the extremes
    write_reg(REG_REAL_ORIGIN, 32'h7FFF_FFFF);
    write_reg(REG_IMAG_ORIGIN, 32'h8000_0000);
    write_reg(REG_REAL_STEP, 32'h7FFF_FFFF);
    write_reg(REG_IMAG_STEP, 32'h8000_0000);
    write_reg(REG_IMAGE_WIDTH, 32'd4096);
    write_reg(REG_IMAGE_HEIGHT, 32'd4096);
    write_reg(REG_CHANNEL_STRIDE, 32'd4);
    begin_batch(2);
    queue_pixel(0, 0);
    queue_pixel(1, 1);
    queue_pixel(4095, 4095);
    wait_drained();

    // Oversized pitch with stride 7: byte index wraps at 26 bits
    write_reg(REG_REAL_ORIGIN, 32'hE000_0000);
    write_reg(REG_IMAG_ORIGIN, 32'hE800_0000);
    write_reg(REG_REAL_STEP, 32'd1);
    write_reg(REG_IMAG_STEP, 32'd1);
    write_reg(REG_IMAGE_WIDTH, 32'h1FFF);
    write_reg(REG_CHANNEL_STRIDE, 32'd7);
    begin_batch(0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    wait_drained();

    // Empty frame: everything lands outside
    write_reg(REG_IMAGE_WIDTH, 32'd0);
    write_reg(REG_IMAGE_HEIGHT, 32'd0);
    write_reg(REG_CHANNEL_STRIDE, 32'd0);
    begin_batch(1);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    wait_drained();

    // Single-pixel frame, stride zero, and a write outside the register map
    write_reg(REG_IMAGE_WIDTH, 32'd1);
    write_reg(REG_IMAGE_HEIGHT, 32'd1);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    begin_batch(2);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(0, 1);
    wait_drained();

    // Random views, each with a burst of pixels, mostly inside the frame
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      choose_view();
      begin_batch(ph % 3);
      wb = (frame_cfg.image_width > MAX_DIM) ? MAX_DIM : frame_cfg.image_width;
      hb = (frame_cfg.image_height > MAX_DIM) ? MAX_DIM : frame_cfg.image_height;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (wb > 0 && hb > 0 && $urandom_range(0, 99) < 85) begin
          col = $urandom_range(0, wb - 1);
          row = $urandom_range(0, hb - 1);
        end else begin
          col = $urandom_range(0, 4095);
          row = $urandom_range(0, 4095);
        end
        queue_pixel(col, row);
      end
      // back-pressure the result side long enough to fill the block
      if (ph == HOLD_PHASE) hold_request = 1'b1;
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (rendered_q.size() != 0) begin
      $display("%0d expected results never arrived", rendered_q.size());
      fail_count += rendered_q.size();
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mbe_pkg.sv
rtl/core/mbe_mul_unit.sv
rtl/core/mbe_result.sv
rtl/core/mbe_seq.sv
rtl/core/mandelbrot_escape_pixel_unit.sv
rtl/core/mbe_checker.sv
dv/tb_top.sv
